FILE: rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by the allocator top level.
package bba_pkg;

   localparam int BLOCK_CAPACITY_DEF = 1024;
   localparam int MAP_WORD_BITS      = 32;
   localparam int BIT_W              = $clog2(MAP_WORD_BITS);

   localparam logic [MAP_WORD_BITS-1:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [15:0] PAYLOAD_SIZE_RST = 16'd1024;
   localparam logic [10:0] MAX_BLOCKS_RST   = 11'd1024;

   // register index, taken from paddr[2]
   localparam logic REG_PAYLOAD_SIZE = 1'b0;
   localparam logic REG_MAX_BLOCKS   = 1'b1;

   typedef enum logic [2:0] {
      ACT_ALLOC   = 3'd0,
      ACT_WRITE   = 3'd1,
      ACT_RESERVE = 3'd2,
      ACT_LOCATE  = 3'd3,
      ACT_GET     = 3'd4,
      ACT_CLEAR   = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_UNUSED   = 3'd2,
      ST_BAD_LOC  = 3'd3,
      ST_TOO_LONG = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_MUL   = 5'b01000,
      S_OFF   = 5'b10000
   } state_type;

endpackage

FILE: rtl/bba_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

FILE: rtl/bitmap_block_allocator.sv
// Bitmap first-fit block allocator, top level.
// Depends on bba_pkg and two bba_ram instances (used map, stored lengths).
//
// A request is taken when start is high and busy is low. A successful action
// passes through used-map/length RAM read, modify and write back, offset
// multiply and offset add. Requests rejected on their fields (bad location,
// length too large, no free word in the summary) are answered from the idle
// state; an allocate whose lowest free bit lies past max_blocks is answered
// from the read state, as is a write-at, locate or get on a free block.
// Actions 6 and 7 are swallowed with no result. Each result shows on the rsp_
// ports for exactly one cycle with rsp_valid high; there is no back-pressure,
// so the receiver must take it then. A new request may be accepted in the same
// cycle a result is shown. After reset the used map is cleared, one word per
// cycle with busy high; CSR writes are taken meanwhile. CSRs should only be
// written while idle.
module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int BLOCK_CAPACITY = BLOCK_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_location,
   input  logic [15:0] req_length_in,
   // result channel
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_location_out,
   output logic [15:0] rsp_length_out,
   output logic [25:0] rsp_data_offset,
   // CSR port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Geometry
   localparam int MAP_WORDS = (BLOCK_CAPACITY + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BLK_W     = (BLOCK_CAPACITY > 1) ? $clog2(BLOCK_CAPACITY) : 1;
   localparam int IDX_W     = WORD_W + BIT_W;         // word:bit index
   localparam int NBLK_W    = IDX_W + 1;              // holds the block count
   localparam int HW_W      = NBLK_W - BIT_W + 1;     // header word count
   localparam int CMP_W     = (NBLK_W > 11) ? NBLK_W : 11;
   localparam int PROD_W    = (IDX_W + 17 > 26) ? IDX_W + 17 : 26;

   // CSRs
   logic [15:0] payload_size_ff, payload_size_in;
   logic [10:0] max_blocks_ff, max_blocks_in;

   // Control
   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [MAP_WORDS-1:0] full_ff, full_in;   // word-full summary
   logic               rsp_valid_ff, rsp_valid_in;

   // Request context
   action_type         act_ff, act_in;
   logic [9:0]         loc_ff, loc_in;
   logic [15:0]        len_ff, len_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [15:0]        lenout_ff, lenout_in;
   logic [25:0]        prod_ff, prod_in;

   // Result registers
   status_type         rsp_status_ff, rsp_status_in;
   logic [9:0]         rsp_loc_ff, rsp_loc_in;
   logic [15:0]        rsp_len_ff, rsp_len_in;
   logic [25:0]        rsp_off_ff, rsp_off_in;

   // RAM ports
   logic                     map_we;
   logic [WORD_W-1:0]        map_waddr, map_raddr;
   logic [MAP_WORD_BITS-1:0] map_wdata, map_rdata;
   logic                     len_we;
   logic [BLK_W-1:0]         len_waddr, len_raddr;
   logic [15:0]              len_wdata, len_rdata;

   // Derived config values
   logic [NBLK_W-1:0] nblk;
   logic [NBLK_W:0]   nblk_sum;
   logic [HW_W-1:0]   hw;
   logic [16:0]       limit;
   logic [16:0]       blk_stride;
   logic [25:0]       hdr_bytes;

   // Search results
   logic              free_any;
   logic [WORD_W-1:0] free_word;
   logic              zero_any;
   logic [BIT_W-1:0]  zero_bit;
   logic [BIT_W-1:0]  bit_sel;
   logic [MAP_WORD_BITS-1:0] bit_mask;
   logic [IDX_W-1:0]  found;
   logic [PROD_W-1:0] prod_full;

   logic req_take;
   logic csr_wr;
   logic too_long_req;
   logic loc_bad_req;

   // ---------------------------------------------------------------------
   // Memories: used map (one word per 32 blocks) and per-block length
   // ---------------------------------------------------------------------
   bba_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock    (clock),
      .we       (map_we),
      .waddr    (map_waddr),
      .wdata    (map_wdata),
      .raddr    (map_raddr),
      .rdata_ff (map_rdata)
   );

   bba_ram #(
      .WIDTH (16),
      .DEPTH (BLOCK_CAPACITY)
   ) u_len_ram (
      .clock    (clock),
      .we       (len_we),
      .waddr    (len_waddr),
      .wdata    (len_wdata),
      .raddr    (len_raddr),
      .rdata_ff (len_rdata)
   );

   // ---------------------------------------------------------------------
   // CSR port
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      payload_size_in = payload_size_ff;
      max_blocks_in   = max_blocks_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_PAYLOAD_SIZE: payload_size_in = pwdata[15:0];
            REG_MAX_BLOCKS:   max_blocks_in   = pwdata[10:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_PAYLOAD_SIZE: prdata = {16'b0, payload_size_ff};
         REG_MAX_BLOCKS:   prdata = {21'b0, max_blocks_ff};
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pool geometry from CSRs
   // ---------------------------------------------------------------------
   // effective block count is max_blocks clamped to the capacity
   assign nblk = (CMP_W'(max_blocks_ff) > CMP_W'(BLOCK_CAPACITY)) ?
                 NBLK_W'(BLOCK_CAPACITY) : NBLK_W'(max_blocks_ff);
   assign nblk_sum   = {1'b0, nblk} + (NBLK_W+1)'(MAP_WORD_BITS - 1);
   assign hw         = nblk_sum[NBLK_W:BIT_W];
   assign hdr_bytes  = 26'({hw, 2'b00});
   assign limit      = {1'b0, payload_size_ff} + 17'd4;
   assign blk_stride = {1'b0, payload_size_ff} + 17'd8;

   assign too_long_req = {1'b0, req_length_in} > limit;
   assign loc_bad_req  = CMP_W'(req_location) >= CMP_W'(nblk);

   // lowest word inside the header span that is not full
   always_comb begin
      free_any  = 1'b0;
      free_word = '0;
      for (int w = MAP_WORDS - 1; w >= 0; w--) begin
         if (!full_ff[w] && (HW_W'(w) < hw)) begin
            free_any  = 1'b1;
            free_word = WORD_W'(w);
         end
      end
   end

   // lowest clear bit of the word just read
   always_comb begin
      zero_any = 1'b0;
      zero_bit = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (!map_rdata[b]) begin
            zero_any = 1'b1;
            zero_bit = BIT_W'(b);
         end
      end
   end

   assign found    = {word_ff, zero_bit};
   assign bit_sel  = (act_ff == ACT_ALLOC) ? zero_bit : loc_ff[BIT_W-1:0];
   assign bit_mask = MAP_WORD_BITS'(1) << bit_sel;

   assign prod_full = PROD_W'(idx_ff) * PROD_W'(blk_stride);

   assign req_take = start && (state_ff == S_IDLE);

   // read addresses are driven straight from the request fields (the summary search for an allocate)
   assign map_raddr = (req_action == ACT_ALLOC) ? free_word
                                                : WORD_W'(req_location >> BIT_W);
   assign len_raddr = BLK_W'(req_location);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      full_in       = full_ff;
      rsp_valid_in  = 1'b0;
      act_in        = act_ff;
      loc_in        = loc_ff;
      len_in        = len_ff;
      word_in       = word_ff;
      idx_in        = idx_ff;
      lenout_in     = lenout_ff;
      prod_in       = prod_ff;
      rsp_status_in = rsp_status_ff;
      rsp_loc_in    = rsp_loc_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_off_in    = rsp_off_ff;
      map_we        = 1'b0;
      map_waddr     = word_ff;
      map_wdata     = map_rdata | bit_mask;
      len_we        = 1'b0;
      len_waddr     = BLK_W'(loc_ff);
      len_wdata     = len_ff;

      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_ff;
            map_wdata = '0;
            if (clr_cnt_ff == WORD_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + WORD_W'(1);
            end
         end

         S_IDLE: begin
            if (req_take) begin
               act_in    = action_type'(req_action);
               loc_in    = req_location;
               len_in    = req_length_in;
               lenout_in = '0;
               idx_in    = IDX_W'(req_location);
               rsp_len_in = '0;
               rsp_off_in = '0;
               priority if (req_action > ACT_CLEAR) begin
                  // unknown action: dropped, no result
               end else if (req_action == ACT_ALLOC) begin
                  if (too_long_req) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_TOO_LONG;
                     rsp_loc_in    = '0;
                  end else if (!free_any) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                     rsp_loc_in    = '0;
                  end else begin
                     word_in  = free_word;
                     state_in = S_READ;
                  end
               end else if (loc_bad_req) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BAD_LOC;
                  rsp_loc_in    = req_location;
               end else if ((req_action == ACT_WRITE || req_action == ACT_RESERVE)
                            && too_long_req) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_TOO_LONG;
                  rsp_loc_in    = req_location;
               end else begin
                  word_in  = WORD_W'(req_location >> BIT_W);
                  state_in = S_READ;
               end
            end
         end

         S_READ: begin
            // map word and stored length are valid now; write back at this edge
            rsp_len_in = '0;
            rsp_off_in = '0;
            state_in   = S_MUL;
            unique case (act_ff)
               ACT_ALLOC: begin
                  if (!zero_any || (CMP_W'(found) >= CMP_W'(nblk))) begin
                     // lowest free bit lies past the pool
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                     rsp_loc_in    = '0;
                     state_in      = S_IDLE;
                  end else begin
                     map_we           = 1'b1;
                     full_in[word_ff] = &(map_rdata | bit_mask);
                     len_we           = 1'b1;
                     len_waddr        = BLK_W'(found);
                     idx_in           = found;
                  end
               end
               ACT_RESERVE: begin
                  map_we           = 1'b1;
                  full_in[word_ff] = &(map_rdata | bit_mask);
                  len_we           = 1'b1;
               end
               ACT_CLEAR: begin
                  map_we           = 1'b1;
                  map_wdata        = map_rdata & ~bit_mask;
                  full_in[word_ff] = 1'b0;
               end
               ACT_WRITE, ACT_LOCATE, ACT_GET: begin
                  if (!map_rdata[bit_sel]) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_UNUSED;
                     rsp_loc_in    = loc_ff;
                     state_in      = S_IDLE;
                  end else if (act_ff == ACT_WRITE) begin
                     len_we = 1'b1;
                  end else begin
                     lenout_in = len_rdata;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_MUL: begin
            prod_in  = prod_full[25:0];
            state_in = S_OFF;
         end

         S_OFF: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_loc_in    = 10'(idx_ff);
            rsp_len_in    = lenout_ff;
            rsp_off_in    = hdr_bytes + prod_ff + 26'd4;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_cnt_ff      <= '0;
         full_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         payload_size_ff <= PAYLOAD_SIZE_RST;
         max_blocks_ff   <= MAX_BLOCKS_RST;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         full_ff         <= full_in;
         rsp_valid_ff    <= rsp_valid_in;
         payload_size_ff <= payload_size_in;
         max_blocks_ff   <= max_blocks_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      loc_ff        <= loc_in;
      len_ff        <= len_in;
      word_ff       <= word_in;
      idx_ff        <= idx_in;
      lenout_ff     <= lenout_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_loc_ff    <= rsp_loc_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_off_ff    <= rsp_off_in;
   end

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_location_out = rsp_loc_ff;
   assign rsp_length_out   = rsp_len_ff;
   assign rsp_data_offset  = rsp_off_ff;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_block_allocator: directed and random requests,
// a scoreboard class that predicts every result, CSR writes between phases.
// Depends on bba_pkg and the allocator RTL only.
module tb;
   import bba_pkg::*;

   localparam int POOL_CAP    = BLOCK_CAPACITY_DEF;
   localparam int MAP_WORDS   = POOL_CAP / MAP_WORD_BITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 150;
   // action codes the block swallows without a result
   localparam logic [2:0] ACT_RSVD6 = 3'd6;
   localparam logic [2:0] ACT_RSVD7 = 3'd7;

   typedef struct packed {
      status_type  status;
      logic [9:0]  location;
      logic [15:0] length;
      logic [25:0] offset;
   } alloc_result_type;

   // Scoreboard: own copy of the used map, stored lengths and both CSRs.
   // note_request() predicts the result of an accepted request and queues it;
   // check_result() compares a strobed result against the oldest prediction.
   class block_pool_model;
      logic [15:0]      payload_size;
      logic [10:0]      max_blocks;
      logic [31:0]      used_map [MAP_WORDS];
      logic [15:0]      stored_len [POOL_CAP];
      alloc_result_type pending [$];
      int               errors;
      int               checked;
      int               accepted;
      int               status_seen [5];

      function new();
         payload_size = PAYLOAD_SIZE_RST;
         max_blocks   = MAX_BLOCKS_RST;
         foreach (used_map[i]) used_map[i] = '0;
         foreach (stored_len[i]) stored_len[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         errors   = 0;
         checked  = 0;
         accepted = 0;
      endfunction

      // max_blocks above the capacity acts as the capacity
      function int pool_blocks();
         return (int'(max_blocks) > POOL_CAP) ? POOL_CAP : int'(max_blocks);
      endfunction

      function bit is_used(int loc);
         return used_map[loc / MAP_WORD_BITS][loc % MAP_WORD_BITS];
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("tb: mismatch: %s", msg);
      endfunction

      function void set_register(logic idx, logic [31:0] value);
         if (idx == REG_PAYLOAD_SIZE) payload_size = value[15:0];
         else max_blocks = value[10:0];
      endfunction

      function void note_request(logic [2:0] act, logic [9:0] loc, logic [15:0] len);
         alloc_result_type r;
         int               nblk;
         int               lim;
         int               hw;
         int               found;
         logic [63:0]      off;
         if (act > ACT_CLEAR) return;
         accepted++;
         nblk = pool_blocks();
         lim  = int'(payload_size) + 4;   // data area of one block
         hw   = (nblk + 31) / 32;         // header words covering the pool
         r.status   = ST_OK;
         r.location = loc;
         r.length   = '0;
         r.offset   = '0;
         if (act == ACT_ALLOC) begin
            r.location = '0;
            if (int'(len) > lim) begin
               r.status = ST_TOO_LONG;
            end else begin
               // lowest clear bit in the header words; full words are skipped
               found = -1;
               for (int w = 0; w < hw && found < 0; w++)
                  if (used_map[w] != WORD_ALL_ONES)
                     for (int b = 0; b < MAP_WORD_BITS && found < 0; b++)
                        if (!used_map[w][b]) found = w * MAP_WORD_BITS + b;
               // a free bit past max_blocks still means a full pool
               if (found < 0 || found >= nblk) begin
                  r.status = ST_FULL;
               end else begin
                  r.location = 10'(found);
                  used_map[found / MAP_WORD_BITS][found % MAP_WORD_BITS] = 1'b1;
                  stored_len[found] = len;
               end
            end
         end else if (int'(loc) >= nblk) begin
            r.status = ST_BAD_LOC;
         end else if ((act == ACT_WRITE || act == ACT_RESERVE) && int'(len) > lim) begin
            r.status = ST_TOO_LONG;
         end else if (act == ACT_RESERVE) begin
            used_map[loc / MAP_WORD_BITS][loc % MAP_WORD_BITS] = 1'b1;
            stored_len[loc] = len;
         end else if (act == ACT_CLEAR) begin
            used_map[loc / MAP_WORD_BITS][loc % MAP_WORD_BITS] = 1'b0;
         end else if (!is_used(int'(loc))) begin
            r.status = ST_UNUSED;
         end else if (act == ACT_WRITE) begin
            stored_len[loc] = len;
         end else begin
            r.length = stored_len[loc];
         end
         if (r.status == ST_OK) begin
            off = 64'(hw) * 64'd4 + 64'(r.location) * (64'(payload_size) + 64'd8) + 64'd4;
            r.offset = off[25:0];
         end
         status_seen[r.status]++;
         pending.push_back(r);
      endfunction

      function void check_result(logic [2:0] st, logic [9:0] loc, logic [15:0] len,
                                 logic [25:0] off);
         alloc_result_type e;
         checked++;
         if (pending.size() == 0) begin
            report($sformatf("result with nothing pending: status %0d loc %0d", st, loc));
            return;
         end
         e = pending.pop_front();
         if (st !== e.status || loc !== e.location || len !== e.length || off !== e.offset)
            report($sformatf(
               "exp/got status %0d/%0d loc %0d/%0d length %0d/%0d offset %0d/%0d",
               e.status, st, e.location, loc, e.length, len, e.offset, off));
      endfunction
   endclass

   logic        clock;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic        busy;
   logic [2:0]  req_action    = '0;
   logic [9:0]  req_location  = '0;
   logic [15:0] req_length_in = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_location_out;
   logic [15:0] rsp_length_out;
   logic [25:0] rsp_data_offset;
   logic        psel          = 1'b0;
   logic        penable       = 1'b0;
   logic        pwrite        = 1'b0;
   logic [2:0]  paddr         = '0;
   logic [31:0] pwdata        = '0;
   logic [31:0] prdata;
   logic        pready;

   block_pool_model pool;
   bit              no_idle      = 1'b0;  // back-to-back stretch: no gaps between requests
   int              settings_run = 0;
   int              cycle_count  = 0;

   bitmap_block_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_location     (req_location),
      .req_length_in    (req_length_in),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_location_out (rsp_location_out),
      .rsp_length_out   (rsp_length_out),
      .rsp_data_offset  (rsp_data_offset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Results cannot be held off, so every strobe is checked at the edge that
   // ends its cycle; values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1)
         pool.check_result(rsp_status, rsp_location_out, rsp_length_out, rsp_data_offset);
   end

   // Hard stop in case a result or a busy release never comes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // One request: optional gap with start low, then hold start until busy is
   // low at an edge. With no gap start stays high, so it gets a single update.
   task automatic send_request(input logic [2:0] act, input logic [9:0] loc,
                               input logic [15:0] len);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_location  <= loc;
      req_length_in <= len;
      do @(posedge clock); while (busy !== 1'b0);
      pool.note_request(act, loc, len);
   endtask

   // Let every pending result come back; the extra cycles cover a swallowed
   // reserved action that may still be in flight.
   task automatic drain(input int extra);
      start <= 1'b0;
      while (pool.pending.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // APB setup + access; psel is dropped before the task returns, so back-to-back calls never
   // update psel twice in one step.
   task automatic csr_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write a CSR, mirror it in the scoreboard, read it back.
   task automatic write_register(input logic idx, input logic [31:0] value);
      logic [31:0] rd;
      logic [31:0] want;
      csr_access({idx, 2'b00}, 1'b1, value, rd);
      pool.set_register(idx, value);
      want = (idx == REG_PAYLOAD_SIZE) ? {16'd0, pool.payload_size} : {21'd0, pool.max_blocks};
      csr_access({idx, 2'b00}, 1'b0, 32'd0, rd);
      if (rd !== want)
         pool.report($sformatf("csr %0d read back %0h, expected %0h", idx, rd, want));
   endtask

   // CSRs change only with the block idle.
   task automatic apply_config(input logic [15:0] ps, input logic [10:0] mb);
      drain(8);
      write_register(REG_PAYLOAD_SIZE, {16'd0, ps});
      write_register(REG_MAX_BLOCKS, {21'd0, mb});
      settings_run++;
   endtask

   initial begin : stimulus
      int          n;
      int          pick;
      int          nblk;
      int          lim;
      logic [2:0]  act;
      logic [9:0]  loc;
      logic [15:0] len;
      logic [15:0] ps;
      logic [10:0] mb;
      pool = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset config (payload 1024, limit 1028, full pool) ----
      send_request(ACT_GET, 10'd0, 16'd0);              // free block
      send_request(ACT_LOCATE, 10'd1023, 16'd0);
      send_request(ACT_WRITE, 10'd5, 16'd9);            // write to free block
      send_request(ACT_ALLOC, 10'd0, 16'd0);            // takes block 0
      send_request(ACT_ALLOC, 10'd1023, 16'd1028);      // length at the limit, block 1
      send_request(ACT_ALLOC, 10'd0, 16'd1029);         // one past the limit
      send_request(ACT_ALLOC, 10'd0, 16'hFFFF);
      send_request(ACT_WRITE, 10'd0, 16'd1028);
      send_request(ACT_WRITE, 10'd0, 16'd1029);
      send_request(ACT_LOCATE, 10'd0, 16'd0);
      send_request(ACT_GET, 10'd1, 16'd0);
      send_request(ACT_RESERVE, 10'd1023, 16'h02AA);    // top block
      send_request(ACT_GET, 10'd1023, 16'd0);
      send_request(ACT_RESERVE, 10'd1022, 16'd1029);
      send_request(ACT_CLEAR, 10'd1, 16'd0);
      send_request(ACT_GET, 10'd1, 16'd0);
      send_request(ACT_ALLOC, 10'd0, 16'h0155);         // refills block 1
      send_request(ACT_CLEAR, 10'd1023, 16'd0);
      send_request(ACT_LOCATE, 10'd1023, 16'd0);
      send_request(ACT_RSVD6, 10'd3, 16'd0);            // swallowed, no result
      send_request(ACT_RSVD7, 10'd4, 16'd0);

      // zero payload (limit 4), two-block pool with both blocks in use
      apply_config(16'd0, 11'd2);
      send_request(ACT_ALLOC, 10'd0, 16'd5);            // length beats pool full
      send_request(ACT_ALLOC, 10'd0, 16'd4);            // free bit 2 is past the pool
      send_request(ACT_RESERVE, 10'd2, 16'hFFFF);       // location checked before length
      // empty pool
      apply_config(16'd0, 11'd0);
      send_request(ACT_ALLOC, 10'd0, 16'd0);
      send_request(ACT_GET, 10'd0, 16'd0);
      // max_blocks above capacity clamps to the capacity
      apply_config(16'hFFFF, 11'd2047);
      send_request(ACT_RESERVE, 10'd1023, 16'hFFFF);
      send_request(ACT_LOCATE, 10'd1023, 16'd0);

      // ---- random phases, one CSR setting each ----
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       begin ps = 16'd65535;                  mb = 11'd1024; end
            1:       begin ps = 16'd0;                      mb = 11'd33;   end
            2:       begin ps = 16'd65531;                  mb = 11'd2047; end
            3:       begin ps = 16'd1024;                   mb = 11'd32;   end
            4:       begin ps = 16'($urandom);              mb = 11'd1;    end
            5:       begin ps = 16'd3;                      mb = 11'd40;   end
            6:       begin ps = 16'd4000;                   mb = 11'd7;    end
            default: begin ps = 16'($urandom_range(0, 300)); mb = 11'($urandom_range(1, 100)); end
         endcase
         apply_config(ps, mb);
         nblk = pool.pool_blocks();
         lim  = int'(pool.payload_size) + 4;
         if (lim > 65535) lim = 65535;
         n = 0;
         while (n < PHASE_ITEMS) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);

            pick = $urandom_range(0, 99);
            if (pick < 30)      act = ACT_ALLOC;
            else if (pick < 42) act = ACT_WRITE;
            else if (pick < 52) act = ACT_RESERVE;
            else if (pick < 64) act = ACT_LOCATE;
            else if (pick < 76) act = ACT_GET;
            else if (pick < 96) act = ACT_CLEAR;
            else if (pick < 98) act = ACT_RSVD6;
            else                act = ACT_RSVD7;

            // mostly inside the pool; lookups lean toward blocks in use
            if (nblk == 0 || $urandom_range(0, 6) == 0) begin
               loc = 10'($urandom_range(0, 1023));
            end else begin
               loc = 10'($urandom_range(0, nblk - 1));
               if (act == ACT_WRITE || act == ACT_LOCATE || act == ACT_GET)
                  for (int k = 0; k < 8 && !pool.is_used(int'(loc)); k++)
                     loc = 10'($urandom_range(0, nblk - 1));
            end

            // lengths cluster below the limit, with boundary and wild values
            pick = $urandom_range(0, 9);
            if (pick == 0)      len = 16'($urandom);
            else if (pick == 1) len = 16'(lim);
            else if (pick == 2) len = (lim == 65535) ? 16'hFFFF : 16'(lim + 1);
            else                len = 16'($urandom_range(0, lim));

            send_request(act, loc, len);
            if (act <= ACT_CLEAR) n++;
            // now and then hold off until the block has answered everything;
            // waiting past the drain keeps start from two updates in one step
            if ($urandom_range(0, 99) == 0) drain(1);
         end
      end

      drain(10);
      $display("tb: %0d requests predicted, %0d results checked, %0d CSR settings, %0d mismatches",
               pool.accepted, pool.checked, settings_run, pool.errors);
      $display("tb: status mix ok %0d, full %0d, unused %0d, bad location %0d, too long %0d",
               pool.status_seen[ST_OK], pool.status_seen[ST_FULL], pool.status_seen[ST_UNUSED],
               pool.status_seen[ST_BAD_LOC], pool.status_seen[ST_TOO_LONG]);
      if (pool.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
